/* src/mlp_pkg.sv */
// Shared types and constants of the minimum-label propagation unit.
`default_nettype none
package mlp_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_PROP  = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLR,
        S_RD_OUT,
        S_P_LBL,
        S_P_WX,
        S_P_WY
    } state_t;

    typedef struct packed {
        logic [6:0] node_count;
        logic [7:0] pass_count;
    } cfg_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_NODE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_PASS_COUNT = 1'b1;

    localparam logic [6:0] NODE_COUNT_RST = 7'd64;
    localparam logic [7:0] PASS_COUNT_RST = 8'd20;

endpackage
`default_nettype wire

/* src/mlp_cfg.sv */
// APB configuration registers: node count and passes per propagate.
`default_nettype none
module mlp_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mlp_pkg::cfg_t     cfg
);
    import mlp_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count <= NODE_COUNT_RST;
            cfg_reg.pass_count <= PASS_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_NODE_COUNT: cfg_reg.node_count <= pwdata[6:0];
                REG_PASS_COUNT: cfg_reg.pass_count <= pwdata[7:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NODE_COUNT: prdata = {25'd0, cfg_reg.node_count};
            REG_PASS_COUNT: prdata = {24'd0, cfg_reg.pass_count};
            default:        prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* src/mlp_label_mem.sv */
// Label memory: one write port, two registered read ports.
`default_nettype none
module mlp_label_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_a_en,
    input  wire logic [AW-1:0] rd_a_addr,
    output logic [DW-1:0]      rd_a_data,
    input  wire logic          rd_b_en,
    input  wire logic [AW-1:0] rd_b_addr,
    output logic [DW-1:0]      rd_b_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule
`default_nettype wire

/* src/mlp_edge_mem.sv */
// Edge store: one write port, one registered read port.
`default_nettype none
module mlp_edge_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 12
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [DW-1:0]      rd_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* src/mlp_seq.sv */
// Sequencer with the shared min-compare unit: clear sweep, add, read, passes.
`default_nettype none
module mlp_seq #(
    parameter int MAX_NODE_COUNT = 64,
    parameter int MAX_EDGE_COUNT = 256,
    parameter int NW  = 6,
    parameter int LW  = 7,
    parameter int EAW = 8,
    parameter int ECW = 9
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mlp_pkg::cfg_t  cfg,
    input  wire logic           start,
    output logic                busy,
    input  wire logic [1:0]     action,
    input  wire logic [6:0]     node_a,
    input  wire logic [6:0]     node_b,
    output logic                done,
    output logic [6:0]          label,
    output logic [1:0]          status,
    output logic [8:0]          edges_held,
    // label memory
    output logic                lw_en,
    output logic [NW-1:0]       lw_addr,
    output logic [LW-1:0]       lw_data,
    output logic                lrx_en,
    output logic [NW-1:0]       lrx_addr,
    input  wire logic [LW-1:0]  lrx_data,
    output logic                lry_en,
    output logic [NW-1:0]       lry_addr,
    input  wire logic [LW-1:0]  lry_data,
    // edge store
    output logic                ew_en,
    output logic [EAW-1:0]      ew_addr,
    output logic [2*NW-1:0]     ew_data,
    output logic                er_en,
    output logic [EAW-1:0]      er_addr,
    input  wire logic [2*NW-1:0] er_data
);
    import mlp_pkg::*;

    state_t          state_reg, state_next;
    act_t            act_reg, act_next;
    logic [6:0]      a_reg, a_next;
    logic [6:0]      b_reg, b_next;
    logic [NW-1:0]   idx_reg, idx_next;
    logic [ECW-1:0]  e_reg, e_next;
    logic [ECW-1:0]  total_reg, total_next;
    logic [7:0]      pass_reg, pass_next;
    logic [LW-1:0]   m_reg, m_next;
    logic [NW-1:0]   y_reg, y_next;
    logic            done_reg, done_next;
    logic [6:0]      label_reg, label_next;
    logic [1:0]      status_reg, status_next;

    logic [ECW-1:0]  e_inc;
    logic            last_edge;
    logic [LW-1:0]   lbl_min;
    logic [7:0]      pass_inc;

    function automatic logic node_ok(input logic [6:0] n);
        return (n != 7'd0) && (n <= cfg.node_count) && (32'(n) <= MAX_NODE_COUNT);
    endfunction

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign label      = label_reg;
    assign status     = status_reg;
    assign edges_held = 9'(total_reg);

    assign e_inc     = e_reg + ECW'(1);
    assign last_edge = (e_inc == total_reg);
    assign lbl_min   = (lrx_data < lry_data) ? lrx_data : lry_data;
    assign pass_inc  = pass_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        pass_reg   <= pass_next;
        m_reg      <= m_next;
        y_reg      <= y_next;
        label_reg  <= label_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        idx_next    = idx_reg;
        e_next      = e_reg;
        total_next  = total_reg;
        pass_next   = pass_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        done_next   = 1'b0;
        label_next  = label_reg;
        status_next = status_reg;

        lw_en    = 1'b0;
        lw_addr  = idx_reg;
        lw_data  = LW'(idx_reg) + LW'(1);
        lrx_en   = 1'b0;
        lrx_addr = er_data[NW-1:0];
        lry_en   = 1'b0;
        lry_addr = er_data[2*NW-1:NW];
        ew_en    = 1'b0;
        ew_addr  = total_reg[EAW-1:0];
        ew_data  = {NW'(b_reg - 7'd1), NW'(a_reg - 7'd1)};
        er_en    = 1'b0;
        er_addr  = '0;

        case (state_reg)
            S_INIT, S_CLR:
            begin
                // sweep labels back to node number, one entry a cycle
                lw_en    = 1'b1;
                idx_next = idx_reg + NW'(1);
                if (idx_reg == NW'(MAX_NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                    if (state_reg == S_CLR)
                    begin
                        done_next   = 1'b1;
                        label_next  = 7'd0;
                        status_next = ST_OK;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = act_t'(action);
                    a_next     = node_a;
                    b_next     = node_b;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                label_next  = 7'd0;
                status_next = ST_OK;
                case (act_reg)
                    ACT_CLEAR:
                    begin
                        total_next = '0;
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    ACT_ADD:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (!node_ok(a_reg) || !node_ok(b_reg))
                        begin
                            status_next = ST_BAD_NODE;
                        end
                        else if (32'(total_reg) >= MAX_EDGE_COUNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ew_en      = 1'b1;
                            total_next = total_reg + ECW'(1);
                        end
                    end
                    ACT_PROP:
                    begin
                        if (cfg.pass_count == 8'd0 || total_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            er_en      = 1'b1;
                            er_addr    = '0;
                            e_next     = '0;
                            pass_next  = 8'd0;
                            state_next = S_P_LBL;
                        end
                    end
                    ACT_READ:
                    begin
                        if (node_ok(a_reg))
                        begin
                            lrx_en     = 1'b1;
                            lrx_addr   = NW'(a_reg - 7'd1);
                            state_next = S_RD_OUT;
                        end
                        else
                        begin
                            status_next = ST_BAD_NODE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD_OUT:
            begin
                label_next = 7'(lrx_data);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_P_LBL:
            begin
                lrx_en     = 1'b1;
                lry_en     = 1'b1;
                state_next = S_P_WX;
            end
            S_P_WX:
            begin
                // edge data still holds this edge; fetch the next one behind it
                lw_en   = 1'b1;
                lw_addr = er_data[NW-1:0];
                lw_data = lbl_min;
                m_next  = lbl_min;
                y_next  = er_data[2*NW-1:NW];
                er_en   = 1'b1;
                er_addr = last_edge ? '0 : e_inc[EAW-1:0];
                state_next = S_P_WY;
            end
            S_P_WY:
            begin
                lw_en   = 1'b1;
                lw_addr = y_reg;
                lw_data = m_reg;
                if (last_edge)
                begin
                    e_next    = '0;
                    pass_next = pass_inc;
                    if (pass_inc == cfg.pass_count)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_P_LBL;
                    end
                end
                else
                begin
                    e_next     = e_inc;
                    state_next = S_P_LBL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/min_label_propagation_unit.sv */
// Add: S_EXEC checks, then done is registered; read: S_EXEC fetches, S_RD_OUT takes.
// Clear: S_CLR sweeps all labels. Propagate: one edge per three steps of the min unit
// (label read, write of the first endpoint, write of the second on the one write port).
// A new item may be taken in the cycle its predecessor's result is strobed.
// The receiver cannot stall; each result stands for one cycle with done high.
// After reset the label memory is swept, every entry, with busy high.
`default_nettype none
module min_label_propagation_unit #(
    parameter int MAX_NODE_COUNT = 64,
    parameter int MAX_EDGE_COUNT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [6:0]  node_a,
    input  wire logic [6:0]  node_b,
    output logic             done,
    output logic [6:0]       label,
    output logic [1:0]       status,
    output logic [8:0]       edges_held,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mlp_pkg::*;

    localparam int NW  = $clog2(MAX_NODE_COUNT);
    localparam int LW  = $clog2(MAX_NODE_COUNT + 1);
    localparam int EAW = (MAX_EDGE_COUNT > 1) ? $clog2(MAX_EDGE_COUNT) : 1;
    localparam int ECW = $clog2(MAX_EDGE_COUNT + 1);

    cfg_t             cfg;
    logic             lw_en, lrx_en, lry_en;
    logic [NW-1:0]    lw_addr, lrx_addr, lry_addr;
    logic [LW-1:0]    lw_data, lrx_data, lry_data;
    logic             ew_en, er_en;
    logic [EAW-1:0]   ew_addr, er_addr;
    logic [2*NW-1:0]  ew_data, er_data;

    mlp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlp_label_mem #(
        .DEPTH (MAX_NODE_COUNT),
        .AW    (NW),
        .DW    (LW)
    ) u_label_mem (
        .clk       (clk),
        .wr_en     (lw_en),
        .wr_addr   (lw_addr),
        .wr_data   (lw_data),
        .rd_a_en   (lrx_en),
        .rd_a_addr (lrx_addr),
        .rd_a_data (lrx_data),
        .rd_b_en   (lry_en),
        .rd_b_addr (lry_addr),
        .rd_b_data (lry_data)
    );

    mlp_edge_mem #(
        .DEPTH (MAX_EDGE_COUNT),
        .AW    (EAW),
        .DW    (2 * NW)
    ) u_edge_mem (
        .clk     (clk),
        .wr_en   (ew_en),
        .wr_addr (ew_addr),
        .wr_data (ew_data),
        .rd_en   (er_en),
        .rd_addr (er_addr),
        .rd_data (er_data)
    );

    mlp_seq #(
        .MAX_NODE_COUNT (MAX_NODE_COUNT),
        .MAX_EDGE_COUNT (MAX_EDGE_COUNT),
        .NW             (NW),
        .LW             (LW),
        .EAW            (EAW),
        .ECW            (ECW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .node_a     (node_a),
        .node_b     (node_b),
        .done       (done),
        .label      (label),
        .status     (status),
        .edges_held (edges_held),
        .lw_en      (lw_en),
        .lw_addr    (lw_addr),
        .lw_data    (lw_data),
        .lrx_en     (lrx_en),
        .lrx_addr   (lrx_addr),
        .lrx_data   (lrx_data),
        .lry_en     (lry_en),
        .lry_addr   (lry_addr),
        .lry_data   (lry_data),
        .ew_en      (ew_en),
        .ew_addr    (ew_addr),
        .ew_data    (ew_data),
        .er_en      (er_en),
        .er_addr    (er_addr),
        .er_data    (er_data)
    );

    // an accepted transfer always leaves the sequencer busy in the cycle after it
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_reject_no_label: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> label == 7'd0)
        else $error("label on a rejected item");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> edges_held == 9'(MAX_EDGE_COUNT))
        else $error("store full flagged below capacity");

endmodule
`default_nettype wire
